// ===== rtl/hs_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and functions of the hmac/sha-256 engine
// no dependencies

package hs_pkg;

    localparam int BLK_WORDS = 16;
    localparam int DIG_WORDS = 8;
    localparam int CNT_W     = 61;
    localparam logic [6:0] KEY_LONG_LEN = 7'd65;
    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5c;

    localparam logic [31:0] IV [DIG_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef enum logic [1:0] {
        PAD_NONE = 2'd0,
        PAD_IN   = 2'd1,
        PAD_OUT  = 2'd2
    } t_pad;

    typedef struct packed {
        logic       byte_we;
        logic       key_we;
        logic       key_clear;
        logic       key_long;
        logic       key_from_dig;
        logic       init;
        logic       load_key;
        t_pad       pad_sel;
        logic       load_inner;
        logic       save_inner;
        logic       pad;
        logic       zero_blk;
        logic       put_len;
        logic       comp_start;
        logic       comp_round;
        logic       comp_add;
        logic       out_load;
        logic [2:0] out_idx;
        logic [7:0] data;
    } t_dp_cmd;

    typedef struct packed {
        logic key_full;
        logic blk_last;
        logic pos_hi;
        logic round_last;
        logic out_free;
    } t_dp_sts;

    function automatic logic [7:0] pad_byte(input t_pad sel);
        logic [7:0] r;
        case (sel)
            PAD_IN:  r = IPAD;
            PAD_OUT: r = OPAD;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/hs_datapath.sv =====
`timescale 1ns / 1ps
// hmac/sha-256 datapath: key store, block buffer, round unit, chain value, output register
// depends on hs_pkg

module hs_datapath import hs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    logic [31:0]      r_hv [DIG_WORDS];
    logic [31:0]      r_v [DIG_WORDS];
    logic [31:0]      r_inner [DIG_WORDS];
    logic [31:0]      r_blk [BLK_WORDS];
    logic [31:0]      r_key [BLK_WORDS];
    logic [6:0]       r_key_len;
    logic [CNT_W-1:0] r_cnt;
    logic [5:0]       r_rnd;
    logic             r_out_valid;
    logic [31:0]      r_out_word;
    logic [2:0]       r_out_idx;

    logic [31:0] t1, t2, sg_hi, sg_lo, w_new;
    logic [31:0] pad_blk [BLK_WORDS];
    logic [31:0] pad_word;
    logic [5:0]  pos;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    assign pos = r_cnt[5:0];
    assign pad_word = {4{pad_byte(i_cmd.pad_sel)}};

    always_comb begin
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(r_rnd) + r_blk[0];
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        sg_lo = rotr(r_blk[1], 7) ^ rotr(r_blk[1], 18) ^ (r_blk[1] >> 3);
        sg_hi = rotr(r_blk[14], 17) ^ rotr(r_blk[14], 19) ^ (r_blk[14] >> 10);
        w_new = r_blk[0] + sg_lo + r_blk[9] + sg_hi;
    end

    // message padding: 0x80 at the fill position, zero above it
    always_comb begin
        for (int k = 0; k < BLK_WORDS; k++) begin
            for (int m = 0; m < 4; m++) begin
                if ({k[3:0], m[1:0]} == pos) begin
                    pad_blk[k][8*(3-m) +: 8] = 8'h80;
                end else if ({k[3:0], m[1:0]} > pos) begin
                    pad_blk[k][8*(3-m) +: 8] = 8'h00;
                end else begin
                    pad_blk[k][8*(3-m) +: 8] = r_blk[k][8*(3-m) +: 8];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.comp_round) begin
            for (int i = 0; i < BLK_WORDS - 1; i++) begin
                r_blk[i] <= r_blk[i+1];
            end
            r_blk[BLK_WORDS-1] <= w_new;
        end else if (i_cmd.load_key) begin
            for (int i = 0; i < BLK_WORDS; i++) begin
                r_blk[i] <= r_key[i] ^ pad_word;
            end
        end else if (i_cmd.load_inner) begin
            for (int i = 0; i < DIG_WORDS; i++) begin
                r_blk[i] <= r_inner[i];
            end
        end else if (i_cmd.pad) begin
            r_blk <= pad_blk;
        end else if (i_cmd.zero_blk) begin
            for (int i = 0; i < BLK_WORDS; i++) begin
                r_blk[i] <= '0;
            end
        end else if (i_cmd.put_len) begin
            r_blk[BLK_WORDS-2] <= r_cnt[CNT_W-1:29];
            r_blk[BLK_WORDS-1] <= {r_cnt[28:0], 3'b000};
        end else if (i_cmd.byte_we) begin
            case (r_cnt[1:0])
                2'd0:    r_blk[r_cnt[5:2]][31:24] <= i_cmd.data;
                2'd1:    r_blk[r_cnt[5:2]][23:16] <= i_cmd.data;
                2'd2:    r_blk[r_cnt[5:2]][15:8]  <= i_cmd.data;
                default: r_blk[r_cnt[5:2]][7:0]   <= i_cmd.data;
            endcase
        end

        if (i_cmd.init) begin
            r_hv <= IV;
        end else if (i_cmd.comp_add) begin
            for (int i = 0; i < DIG_WORDS; i++) begin
                r_hv[i] <= r_hv[i] + r_v[i];
            end
        end

        if (i_cmd.comp_start) begin
            r_v <= r_hv;
        end else if (i_cmd.comp_round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end

        if (i_cmd.save_inner) begin
            r_inner <= r_hv;
        end

        if (i_cmd.out_load) begin
            r_out_word <= r_hv[i_cmd.out_idx];
            r_out_idx  <= i_cmd.out_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BLK_WORDS; i++) begin
                r_key[i] <= '0;
            end
            r_key_len   <= '0;
            r_cnt       <= '0;
            r_rnd       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.key_clear) begin
                for (int i = 0; i < BLK_WORDS; i++) begin
                    r_key[i] <= '0;
                end
                r_key_len <= '0;
            end else if (i_cmd.key_we) begin
                case (r_key_len[1:0])
                    2'd0:    r_key[r_key_len[5:2]][31:24] <= i_cmd.data;
                    2'd1:    r_key[r_key_len[5:2]][23:16] <= i_cmd.data;
                    2'd2:    r_key[r_key_len[5:2]][15:8]  <= i_cmd.data;
                    default: r_key[r_key_len[5:2]][7:0]   <= i_cmd.data;
                endcase
                r_key_len <= r_key_len + 7'd1;
            end else if (i_cmd.key_long) begin
                r_key_len <= KEY_LONG_LEN;
            end else if (i_cmd.key_from_dig) begin
                for (int i = 0; i < BLK_WORDS; i++) begin
                    r_key[i] <= (i < DIG_WORDS) ? r_hv[i % DIG_WORDS] : 32'h0;
                end
            end

            if (i_cmd.init) begin
                r_cnt <= '0;
            end else if (i_cmd.load_key) begin
                r_cnt <= r_cnt + CNT_W'(64);
            end else if (i_cmd.load_inner) begin
                r_cnt <= r_cnt + CNT_W'(32);
            end else if (i_cmd.byte_we) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end

            if (i_cmd.comp_start) begin
                r_rnd <= '0;
            end else if (i_cmd.comp_round) begin
                r_rnd <= r_rnd + 6'd1;
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.key_full   = r_key_len[6];
    assign o_sts.blk_last   = &r_cnt[5:0];
    assign o_sts.pos_hi     = &r_cnt[5:3];
    assign o_sts.round_last = &r_rnd;
    assign o_sts.out_free   = !r_out_valid || !i_stall;

    assign o_valid       = r_out_valid;
    assign o_digest_word = r_out_word;
    assign o_word_index  = r_out_idx;
    assign o_last_word   = &r_out_idx;

    key_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_len <= KEY_LONG_LEN)
        else $error("key length out of range");

endmodule

// ===== rtl/hs_ctrl.sv =====
`timescale 1ns / 1ps
// hmac/sha-256 controller: section phase, mode register and command sequencer
// depends on hs_pkg

module hs_ctrl import hs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_cfg_wdata,
    input  logic    i_valid,
    output logic    o_stall,
    input  logic    i_operation,
    input  logic [7:0] i_data_byte,
    input  logic    i_byte_present,
    input  logic    i_section_end,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [21:0] {
        S_IN     = 22'h000001,
        S_DEC    = 22'h000002,
        S_KEYB   = 22'h000004,
        S_LKLOAD = 22'h000008,
        S_LKB    = 22'h000010,
        S_KEYE   = 22'h000020,
        S_KEYD   = 22'h000040,
        S_MCLOSE = 22'h000080,
        S_MSTART = 22'h000100,
        S_MLOADK = 22'h000200,
        S_MBYTE  = 22'h000400,
        S_MEND   = 22'h000800,
        S_MOUT1  = 22'h001000,
        S_OLOADK = 22'h002000,
        S_OINNER = 22'h004000,
        S_OUT    = 22'h008000,
        S_CSTART = 22'h010000,
        S_CRND   = 22'h020000,
        S_CADD   = 22'h040000,
        S_FPAD   = 22'h080000,
        S_FZERO  = 22'h100000,
        S_FLEN   = 22'h200000
    } t_state;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_KEY_SHORT = 5'b00010,
        PH_KEY_LONG  = 5'b00100,
        PH_MSG_PLAIN = 5'b01000,
        PH_MSG_HMAC  = 5'b10000
    } t_phase;

    t_state     r_state, n_state, r_cret, n_cret, r_fret, n_fret;
    t_phase     r_phase, n_phase;
    logic [2:0] r_oidx, n_oidx;
    logic       r_mode;
    logic       r_op, r_pres, r_end;
    logic [7:0] r_byte;
    logic       in_key;

    assign in_key  = (r_phase == PH_KEY_SHORT) || (r_phase == PH_KEY_LONG);
    assign o_stall = (r_state != S_IN);

    always_comb begin
        n_state = r_state;
        n_cret  = r_cret;
        n_fret  = r_fret;
        n_phase = r_phase;
        n_oidx  = r_oidx;
        o_cmd   = '0;
        o_cmd.data    = r_byte;
        o_cmd.out_idx = r_oidx;
        case (r_state)
            S_IN: begin
                if (i_valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (r_op) begin
                    n_state = S_MCLOSE;
                end else if (!r_mode) begin
                    n_state = S_IN;
                end else begin
                    if (!in_key) begin
                        o_cmd.key_clear = 1'b1;
                        n_phase = PH_KEY_SHORT;
                    end
                    n_state = S_KEYB;
                end
            end
            S_KEYB: begin
                n_state = S_KEYE;
                if (r_pres) begin
                    if (r_phase == PH_KEY_LONG) begin
                        o_cmd.byte_we = 1'b1;
                        if (i_sts.blk_last) begin
                            n_cret  = S_KEYE;
                            n_state = S_CSTART;
                        end
                    end else if (!i_sts.key_full) begin
                        o_cmd.key_we = 1'b1;
                    end else begin
                        o_cmd.init = 1'b1;
                        n_state = S_LKLOAD;
                    end
                end
            end
            S_LKLOAD: begin
                o_cmd.load_key = 1'b1;
                o_cmd.pad_sel  = PAD_NONE;
                n_cret  = S_LKB;
                n_state = S_CSTART;
            end
            S_LKB: begin
                o_cmd.byte_we  = 1'b1;
                o_cmd.key_long = 1'b1;
                n_phase = PH_KEY_LONG;
                n_state = S_KEYE;
            end
            S_KEYE: begin
                n_state = S_IN;
                if (r_end) begin
                    if (r_phase == PH_KEY_LONG) begin
                        n_fret  = S_KEYD;
                        n_state = S_FPAD;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
            end
            S_KEYD: begin
                o_cmd.key_from_dig = 1'b1;
                n_phase = PH_IDLE;
                n_state = r_op ? S_MSTART : S_IN;
            end
            S_MCLOSE: begin
                n_state = S_MSTART;
                if (r_phase == PH_KEY_LONG) begin
                    n_fret  = S_KEYD;
                    n_state = S_FPAD;
                end else if (r_phase == PH_KEY_SHORT) begin
                    n_phase = PH_IDLE;
                end
            end
            S_MSTART: begin
                n_state = S_MBYTE;
                if (r_phase == PH_IDLE) begin
                    o_cmd.init = 1'b1;
                    if (r_mode) begin
                        n_phase = PH_MSG_HMAC;
                        n_state = S_MLOADK;
                    end else begin
                        n_phase = PH_MSG_PLAIN;
                    end
                end
            end
            S_MLOADK: begin
                o_cmd.load_key = 1'b1;
                o_cmd.pad_sel  = PAD_IN;
                n_cret  = S_MBYTE;
                n_state = S_CSTART;
            end
            S_MBYTE: begin
                n_state = S_MEND;
                if (r_pres) begin
                    o_cmd.byte_we = 1'b1;
                    if (i_sts.blk_last) begin
                        n_cret  = S_MEND;
                        n_state = S_CSTART;
                    end
                end
            end
            S_MEND: begin
                if (r_end) begin
                    n_fret  = S_MOUT1;
                    n_state = S_FPAD;
                end else begin
                    n_state = S_IN;
                end
            end
            S_MOUT1: begin
                n_state = S_OUT;
                if (r_phase == PH_MSG_HMAC) begin
                    o_cmd.save_inner = 1'b1;
                    o_cmd.init       = 1'b1;
                    n_state = S_OLOADK;
                end
                n_phase = PH_IDLE;
            end
            S_OLOADK: begin
                o_cmd.load_key = 1'b1;
                o_cmd.pad_sel  = PAD_OUT;
                n_cret  = S_OINNER;
                n_state = S_CSTART;
            end
            S_OINNER: begin
                o_cmd.load_inner = 1'b1;
                n_fret  = S_OUT;
                n_state = S_FPAD;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_oidx = r_oidx + 3'd1;
                    if (&r_oidx) begin
                        n_state = S_IN;
                    end
                end
            end
            S_CSTART: begin
                o_cmd.comp_start = 1'b1;
                n_state = S_CRND;
            end
            S_CRND: begin
                o_cmd.comp_round = 1'b1;
                if (i_sts.round_last) begin
                    n_state = S_CADD;
                end
            end
            S_CADD: begin
                o_cmd.comp_add = 1'b1;
                n_state = r_cret;
            end
            S_FPAD: begin
                o_cmd.pad = 1'b1;
                if (i_sts.pos_hi) begin
                    n_cret  = S_FZERO;
                    n_state = S_CSTART;
                end else begin
                    n_state = S_FLEN;
                end
            end
            S_FZERO: begin
                o_cmd.zero_blk = 1'b1;
                n_state = S_FLEN;
            end
            S_FLEN: begin
                o_cmd.put_len = 1'b1;
                n_cret  = r_fret;
                n_state = S_CSTART;
            end
            default: begin
                n_state = S_IN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_cret  <= S_IN;
            r_fret  <= S_IN;
            r_phase <= PH_IDLE;
            r_oidx  <= '0;
            r_mode  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_cret  <= n_cret;
            r_fret  <= n_fret;
            r_phase <= n_phase;
            r_oidx  <= n_oidx;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_op   <= i_operation;
            r_byte <= i_data_byte;
            r_pres <= i_byte_present;
            r_end  <= i_section_end;
        end
    end

    rounds_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CRND) && !i_sts.round_last |=> r_state == S_CRND)
        else $error("compression left early");

    transfer_decoded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IN) && i_valid |=> r_state == S_DEC)
        else $error("accepted transfer not decoded");

    out_phase_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> r_phase == PH_IDLE)
        else $error("digest output with open section");

endmodule

// ===== rtl/hmac_sha256_engine_unit.sv =====
`timescale 1ns / 1ps
// Streaming SHA-256 / HMAC-SHA-256 engine. Each message or key byte transfer
// runs through the controller's decode states; the input stalls in between.
// Each filled 64-byte block goes through the one-round-per-cycle compression
// unit, and so does the padded key block that opens an HMAC message. The end
// of a message adds padding and one or two compressions. In HMAC mode the
// outer hash follows over the outer padded key block and the inner digest.
// The eight digest words then leave one per cycle while the receiver does not
// stall. The input stalls for the whole of that work.
// top level; depends on hs_pkg, hs_ctrl, hs_datapath

module hmac_sha256_engine_unit import hs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_section_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    hs_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_section_end  (i_section_end),
        .i_sts          (sts),
        .o_cmd          (cmd)
    );

    hs_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

// ===== tb/tb_hmac_sha256_engine_unit.sv =====
`timescale 1ns / 1ps
// self-checking testbench of hmac_sha256_engine_unit: byte streams, key loads, mode changes
// depends on hs_pkg and the engine rtl; expected digests come from an in-bench sha-256 model

module tb_hmac_sha256_engine_unit;
    import hs_pkg::*;

    localparam int  CYCLE_LIMIT = 600000;
    localparam int  DRAIN_WAIT  = 400;
    localparam bit  OP_KEY      = 1'b0;
    localparam bit  OP_MSG      = 1'b1;
    localparam bit  MODE_PLAIN  = 1'b0;
    localparam bit  MODE_HMAC   = 1'b1;

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum int {
        ST_IDLE, ST_KEY_SHORT, ST_KEY_LONG, ST_MSG_PLAIN, ST_MSG_HMAC
    } t_sect;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_word;

    class digest_board;
        bit             hmac_on;
        logic [7:0]     key_blk [64];
        int             key_len;
        logic [31:0]    chain [8];
        logic [7:0]     blk [64];
        logic [60:0]    nbytes;
        logic [31:0]    inner [8];
        t_sect          sect;
        t_digest_word   pending [$];
        int             errors;

        function new();
            hmac_on = MODE_HMAC;
            foreach (key_blk[i]) key_blk[i] = 8'h00;
            key_len = 0;
            nbytes  = '0;
            sect    = ST_IDLE;
            errors  = 0;
        endfunction

        function logic [31:0] rotr(input logic [31:0] x, input int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] s0, s1, t1, t2;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 16; i < 64; i++) begin
                s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            for (int i = 0; i < 8; i++) v[i] = chain[i];
            for (int i = 0; i < 64; i++) begin
                t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + w[i];
                t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] += v[i];
        endfunction

        function void begin_hash();
            for (int i = 0; i < 8; i++) chain[i] = IV[i];
            nbytes = '0;
        endfunction

        function void absorb(input logic [7:0] b);
            blk[nbytes[5:0]] = b;
            nbytes++;
            if (nbytes[5:0] == 6'd0) compress();
        endfunction

        function void begin_keyed(input logic [7:0] pad);
            begin_hash();
            for (int i = 0; i < 64; i++) absorb(key_blk[i] ^ pad);
        endfunction

        function void finish_hash();
            logic [63:0] bits;
            int pos;
            bits = {nbytes, 3'b000};
            pos = int'(nbytes[5:0]);
            blk[pos++] = 8'h80;
            if (pos > 56) begin
                while (pos < 64) blk[pos++] = 8'h00;
                compress();
                pos = 0;
            end
            while (pos < 56) blk[pos++] = 8'h00;
            for (int i = 0; i < 8; i++) blk[56+i] = bits[63 - 8*i -: 8];
            compress();
        endfunction

        function void add_key_byte(input logic [7:0] b);
            if (sect == ST_KEY_LONG) begin
                absorb(b);
            end else if (key_len < 64) begin
                key_blk[key_len] = b;
                key_len++;
            end else begin
                begin_hash();
                for (int i = 0; i < 64; i++) absorb(key_blk[i]);
                absorb(b);
                key_len = 65;
                sect = ST_KEY_LONG;
            end
        endfunction

        function void close_key();
            if (sect == ST_KEY_LONG) begin
                finish_hash();
                for (int i = 0; i < 64; i++)
                    key_blk[i] = (i < 32) ? chain[i/4][31 - 8*(i%4) -: 8] : 8'h00;
            end
            sect = ST_IDLE;
        endfunction

        function void note_transfer(input bit op, input logic [7:0] b, input bit pres,
                                    input bit fin);
            t_digest_word d;
            if (op == OP_KEY) begin
                if (!hmac_on) return;
                if (sect != ST_KEY_SHORT && sect != ST_KEY_LONG) begin
                    foreach (key_blk[i]) key_blk[i] = 8'h00;
                    key_len = 0;
                    sect = ST_KEY_SHORT;
                end
                if (pres) add_key_byte(b);
                if (fin) close_key();
                return;
            end
            if (sect == ST_KEY_SHORT || sect == ST_KEY_LONG) close_key();
            if (sect == ST_IDLE) begin
                if (hmac_on) begin
                    begin_keyed(IPAD);
                    sect = ST_MSG_HMAC;
                end else begin
                    begin_hash();
                    sect = ST_MSG_PLAIN;
                end
            end
            if (pres) absorb(b);
            if (!fin) return;
            finish_hash();
            if (sect == ST_MSG_HMAC) begin
                for (int i = 0; i < 8; i++) inner[i] = chain[i];
                begin_keyed(OPAD);
                for (int i = 0; i < 32; i++) absorb(inner[i/4][31 - 8*(i%4) -: 8]);
                finish_hash();
            end
            sect = ST_IDLE;
            for (int i = 0; i < 8; i++) begin
                d.word = chain[i];
                d.idx  = i[2:0];
                d.last = (i == 7);
                pending.push_back(d);
            end
        endfunction

        task report(input string what);
            $display("error: %s", what);
            errors++;
        endtask

        task check_word(input logic [31:0] w, input logic [2:0] idx, input logic last);
            t_digest_word d;
            if (pending.size() == 0) begin
                report($sformatf("unexpected digest word %h index %0d", w, idx));
                return;
            end
            d = pending.pop_front();
            if (w !== d.word)
                report($sformatf("word %0d: got %h want %h", d.idx, w, d.word));
            if (idx !== d.idx)
                report($sformatf("word index: got %0d want %0d", idx, d.idx));
            if (last !== d.last)
                report($sformatf("last flag on word %0d: got %b want %b", d.idx, last, d.last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_valid;
    logic        o_stall;
    logic        i_operation;
    logic [7:0]  i_data_byte;
    logic        i_byte_present;
    logic        i_section_end;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    digest_board board;
    int  cycles;
    int  sent;
    bit  quiet;
    int  stall_left;

    hmac_sha256_engine_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_section_end  (i_section_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digest_word  (o_digest_word),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("hmac_sha256_engine_unit: mismatch");
            $finish;
        end
    end

    // receiver stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 17);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_word(o_digest_word, o_word_index, o_last_word);
    end

    task automatic send(input bit op, input logic [7:0] b, input bit pres, input bit fin);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_data_byte    <= b;
        i_byte_present <= pres;
        i_section_end  <= fin;
        do @(posedge i_clk); while (o_stall);
        board.note_transfer(op, b, pres, fin);
        sent++;
    endtask

    task automatic send_section(input bit op, input int len, input bit close);
        bit by_empty;
        by_empty = (len == 0) || ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) send(op, 8'($urandom), 1'b0, 1'b0);
            send(op, 8'($urandom), 1'b1, close && !by_empty && (i == len - 1));
        end
        if (close && by_empty) send(op, 8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic set_mode(input bit mode);
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        board.hmac_on = mode;
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int kind;
        board = new();
        cycles = 0;
        sent = 0;
        quiet = 1'b0;
        stall_left = 0;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= 1'b0;
        i_valid        <= 1'b0;
        i_operation    <= 1'b0;
        i_data_byte    <= 8'h00;
        i_byte_present <= 1'b0;
        i_section_end  <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // hmac mode straight out of reset
        send(OP_KEY, 8'h00, 1'b0, 1'b1);
        send(OP_MSG, 8'h00, 1'b0, 1'b1);
        send(OP_KEY, 8'h00, 1'b1, 1'b0);
        send(OP_KEY, 8'hff, 1'b1, 1'b0);
        send(OP_KEY, 8'ha5, 1'b1, 1'b1);
        send(OP_MSG, 8'hff, 1'b1, 1'b0);
        send(OP_MSG, 8'h00, 1'b1, 1'b1);
        // message opens while the key section is still open
        send(OP_KEY, 8'h12, 1'b1, 1'b0);
        send(OP_MSG, 8'h34, 1'b1, 1'b1);
        // key transfer abandons a running message
        send(OP_MSG, 8'h55, 1'b1, 1'b0);
        send(OP_KEY, 8'h66, 1'b1, 1'b1);
        send(OP_MSG, 8'h00, 1'b0, 1'b1);
        set_mode(MODE_PLAIN);
        send(OP_KEY, 8'hff, 1'b1, 1'b1);
        send(OP_MSG, 8'h61, 1'b1, 1'b0);
        send(OP_MSG, 8'h62, 1'b1, 1'b0);
        send(OP_MSG, 8'h63, 1'b1, 1'b1);
        send(OP_MSG, 8'hff, 1'b0, 1'b1);
        set_mode(MODE_HMAC);

        while (sent < 195) begin
            if (sent >= 160) quiet = 1'b1;
            kind = $urandom_range(0, 11);
            if (kind <= 2) begin
                send_section(OP_KEY, (sent < 120 && $urandom_range(0, 9) == 0)
                             ? $urandom_range(65, 72) : $urandom_range(0, 8),
                             $urandom_range(0, 5) != 0);
            end else if (kind <= 9) begin
                send_section(OP_MSG, (sent < 120 && $urandom_range(0, 9) == 0)
                             ? $urandom_range(50, 130) : $urandom_range(0, 12), 1'b1);
            end else if (kind == 10) begin
                send_section(OP_MSG, $urandom_range(1, 6), 1'b0);
                send_section(OP_KEY, $urandom_range(0, 8), 1'b1);
            end else begin
                set_mode(1'($urandom_range(0, 1)));
                send_section(OP_MSG, $urandom_range(0, 12), 1'b1);
            end
        end
        send_section(OP_MSG, $urandom_range(0, 8), 1'b1);
        i_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("hmac_sha256_engine_unit: match");
        end else begin
            $display("hmac_sha256_engine_unit: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hs_pkg.sv
rtl/hs_datapath.sv
rtl/hs_ctrl.sv
rtl/hmac_sha256_engine_unit.sv
tb/tb_hmac_sha256_engine_unit.sv
